>>> sv/assert_macros.svh
// Assertion macros included by the RTL design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition implies another one at the same clock edge.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Checks that a condition implies another one at the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> sv/jmsl_pkg.sv
package jmsl_pkg;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
  localparam logic [2:0] STATUS_NO_DQT0   = 3'd3;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [7:0] MARKER_SOI  = 8'hD8;
  localparam logic [7:0] MARKER_EOI  = 8'hD9;
  localparam logic [7:0] MARKER_SOS  = 8'hDA;
  localparam logic [7:0] MARKER_DQT  = 8'hDB;
  localparam logic [7:0] MARKER_APP0 = 8'hE0;
  localparam logic [7:0] MARKER_DHT  = 8'hC4;
  localparam logic [7:0] MARKER_SOF0 = 8'hC0;

  localparam logic [2:0] PHASE_DQT0 = 3'd0;
  localparam logic [2:0] PHASE_DQT1 = 3'd1;
  localparam logic [2:0] PHASE_SOS  = 3'd2;
  localparam logic [2:0] PHASE_EOI  = 3'd3;
  localparam logic [2:0] PHASE_DONE = 3'd4;

  localparam logic [2:0] STG_FRAME    = 3'd0;
  localparam logic [2:0] STG_MARKER   = 3'd1;
  localparam logic [2:0] STG_LEN_HI   = 3'd2;
  localparam logic [2:0] STG_LEN_LO   = 3'd3;
  localparam logic [2:0] STG_SOS_HI   = 3'd4;
  localparam logic [2:0] STG_SOS_LO   = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] quant0_offset;
    logic [19:0] quant1_offset;
    logic [19:0] scan_start;
    logic [20:0] scan_length;
  } result_t;

endpackage

>>> sv/jpeg_marker_segment_locator_unit.sv
// Scans one JPEG frame at one byte per cycle and, on the byte flagged as last,
// returns one transaction with a status and the offsets of the first two DQT
// markers, the scan data start after the SOS header and the scan length up to
// EOI. A byte is taken every cycle: all parsing is a counter and compare update
// of the scan state registers, and results sit in an output register backed by
// one skid register, so input is held off only when both are full.
module jpeg_marker_segment_locator_unit
  import jmsl_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [19:0] quant0_offset_o,
  output logic [19:0] quant1_offset_o,
  output logic [19:0] scan_start_o,
  output logic [20:0] scan_length_o
);

`include "assert_macros.svh"

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int OFF_W = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam int EXT_W = (OFF_W > 21) ? OFF_W : 21;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      skip_q, skip_d;
  logic [2:0]       phase_q, phase_d;
  logic [2:0]       stage_q, stage_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [POS_W-1:0] f0_q, f0_d, f1_q, f1_d, f3_q, f3_d;
  logic [OFF_W-1:0] f2_q, f2_d;
  logic [1:0]       hdr_q, hdr_d;

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  result_t res;

  logic in_acc, out_pop, push;
  logic [7:0]       tgt;
  logic [15:0]      len_w;
  logic [POS_W-1:0] pos_m1;
  logic [EXT_W-1:0] slen;
  logic             is_len_seg;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_pop    = out_vld_q && !out_stall_i;
  assign push       = in_acc && last_byte_i;
  assign in_stall_o = skid_vld_q;

  assign tgt = (phase_q < PHASE_SOS) ? MARKER_DQT :
               ((phase_q == PHASE_SOS) ? MARKER_SOS : MARKER_EOI);
  assign is_len_seg = (data_byte_i == MARKER_APP0) || (data_byte_i == MARKER_DQT) ||
                      (data_byte_i == MARKER_DHT) || (data_byte_i == MARKER_SOF0) ||
                      (data_byte_i == MARKER_SOS);
  assign len_w  = {len_hi_q, data_byte_i};
  assign pos_m1 = pos_q - POS_W'(1);

  always_comb begin
    pos_d    = pos_q;
    skip_d   = skip_q;
    phase_d  = phase_q;
    stage_d  = stage_q;
    len_hi_d = len_hi_q;
    f0_d     = f0_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    f3_d     = f3_q;
    hdr_d    = hdr_q;
    if (in_acc && (pos_q < MAX_POS)) begin
      if ((pos_q == POS_W'(0)) && (data_byte_i == BYTE_FF)) begin
        hdr_d[0] = 1'b1;
      end
      if ((pos_q == POS_W'(1)) && (data_byte_i == MARKER_SOI)) begin
        hdr_d[1] = 1'b1;
      end
      pos_d = pos_q + POS_W'(1);
      if (phase_q < PHASE_DONE) begin
        if (skip_q != 16'd0) begin
          skip_d = skip_q - 16'd1;
        end else begin
          case (stage_q)
            STG_FRAME: begin
              if (data_byte_i == BYTE_FF) begin
                stage_d = STG_MARKER;
              end
            end
            STG_MARKER: begin
              stage_d = STG_FRAME;
              if ((data_byte_i != BYTE_ZERO) && (data_byte_i != BYTE_FF)) begin
                if (data_byte_i == tgt) begin
                  case (phase_q)
                    PHASE_DQT0: begin
                      f0_d    = pos_m1;
                      stage_d = STG_LEN_HI;
                    end
                    PHASE_DQT1: begin
                      f1_d    = pos_m1;
                      stage_d = STG_LEN_HI;
                    end
                    PHASE_SOS: begin
                      f2_d    = OFF_W'(pos_m1);
                      stage_d = STG_SOS_HI;
                    end
                    default: begin
                      f3_d    = pos_m1;
                      stage_d = STG_FRAME;
                    end
                  endcase
                  phase_d = phase_q + 3'd1;
                end else if (is_len_seg) begin
                  stage_d = STG_LEN_HI;
                end
              end
            end
            STG_LEN_HI, STG_SOS_HI: begin
              len_hi_d = data_byte_i;
              stage_d  = stage_q + 3'd1;
            end
            STG_LEN_LO, STG_SOS_LO: begin
              if (stage_q == STG_SOS_LO) begin
                f2_d = OFF_W'(pos_m1) + OFF_W'(len_w);
              end
              skip_d  = (len_w < 16'd2) ? 16'd0 : (len_w - 16'd2);
              stage_d = STG_FRAME;
            end
            default: begin
              stage_d = STG_FRAME;
            end
          endcase
        end
      end
    end

    slen = (EXT_W'(f3_d) >= EXT_W'(f2_d)) ? (EXT_W'(f3_d) - EXT_W'(f2_d)) : '0;
    res  = '0;
    if (pos_d < POS_W'(4)) begin
      res.status = STATUS_SHORT;
    end else if (hdr_d != 2'b11) begin
      res.status = STATUS_BAD_MAGIC;
    end else if (phase_d < PHASE_DONE) begin
      res.status = STATUS_NO_DQT0 + phase_d;
    end else begin
      res.status        = STATUS_OK;
      res.quant0_offset = 20'(EXT_W'(f0_d));
      res.quant1_offset = 20'(EXT_W'(f1_d));
      res.scan_start    = 20'(EXT_W'(f2_d));
      res.scan_length   = slen[20:0];
    end

    if (push) begin
      pos_d    = '0;
      skip_d   = '0;
      phase_d  = PHASE_DQT0;
      stage_d  = STG_FRAME;
      len_hi_d = '0;
      f0_d     = '0;
      f1_d     = '0;
      f2_d     = '0;
      f3_d     = '0;
      hdr_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      skip_q     <= '0;
      phase_q    <= PHASE_DQT0;
      stage_q    <= STG_FRAME;
      len_hi_q   <= '0;
      f0_q       <= '0;
      f1_q       <= '0;
      f2_q       <= '0;
      f3_q       <= '0;
      hdr_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      skip_q   <= skip_d;
      phase_q  <= phase_d;
      stage_q  <= stage_d;
      len_hi_q <= len_hi_d;
      f0_q     <= f0_d;
      f1_q     <= f1_d;
      f2_q     <= f2_d;
      f3_q     <= f3_d;
      hdr_q    <= hdr_d;
      if (out_pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else if (!push) begin
          out_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (out_vld_q) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_vld_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign quant0_offset_o = out_q.quant0_offset;
  assign quant1_offset_o = out_q.quant1_offset;
  assign scan_start_o    = out_q.scan_start;
  assign scan_length_o   = out_q.scan_length;

  `ASSERT_IMPLY(a_skid_needs_out, skid_vld_q, out_vld_q, "skid register full with output empty")
  `ASSERT_CLK(a_phase_range, (phase_q <= PHASE_DONE), "search phase out of range")
  `ASSERT_IMPLY(a_skip_in_frame, (skip_q != 16'd0), (stage_q == STG_FRAME), "skip during marker")
  `ASSERT_NEXT(a_last_clears, push, (pos_q == '0) && (phase_q == PHASE_DQT0), "no clear after frame")
  `ASSERT_NEXT(a_last_shows, (push && !out_vld_q), out_vld_q, "result not presented")

endmodule

>>> sim/tb_jpeg_marker_segment_locator_unit.sv
module tb_jpeg_marker_segment_locator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jmsl_pkg::*;

  localparam int FRAME_LIMIT = 1048576;
  localparam int TARGET_BYTES = 950;
  localparam int MAX_WAIT = 12;

  localparam logic [7:0] MARKER_COM  = 8'hFE;
  localparam logic [7:0] MARKER_RST0 = 8'hD0;

  class marker_scoreboard;
    logic [20:0] byte_pos;
    logic [16:0] skip_left;
    logic [2:0]  phase;
    logic [2:0]  stage;
    logic [7:0]  len_hi;
    logic [20:0] marker_at [4];
    logic [1:0]  magic_seen;
    result_t     expected_reports [$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      byte_pos = '0;
      skip_left = '0;
      phase = PHASE_DQT0;
      stage = STG_FRAME;
      len_hi = '0;
      for (int i = 0; i < 4; i++) marker_at[i] = '0;
      magic_seen = '0;
    endfunction

    // Advances the frame scan by one accepted byte and, on the final byte,
    // queues the report the block must return.
    function void take_byte(logic [7:0] b, logic last);
      logic [7:0]  want;
      int unsigned seg_len;
      result_t     rep;
      if (byte_pos < FRAME_LIMIT) begin
        if (byte_pos == 0 && b == BYTE_FF) magic_seen[0] = 1'b1;
        if (byte_pos == 1 && b == MARKER_SOI) magic_seen[1] = 1'b1;
        if (phase < PHASE_DONE) begin
          if (skip_left != 0) begin
            skip_left--;
          end else begin
            case (stage)
              STG_FRAME: begin
                if (b == BYTE_FF) stage = STG_MARKER;
              end
              STG_MARKER: begin
                stage = STG_FRAME;
                if (phase < PHASE_SOS) want = MARKER_DQT;
                else if (phase == PHASE_SOS) want = MARKER_SOS;
                else want = MARKER_EOI;
                if (b != BYTE_ZERO && b != BYTE_FF) begin
                  if (b == want) begin
                    marker_at[phase[1:0]] = byte_pos - 21'd1;
                    if (phase == PHASE_SOS) stage = STG_SOS_HI;
                    else if (phase != PHASE_EOI) stage = STG_LEN_HI;
                    phase++;
                  end else if (b == MARKER_APP0 || b == MARKER_DQT || b == MARKER_DHT ||
                               b == MARKER_SOF0 || b == MARKER_SOS) begin
                    stage = STG_LEN_HI;
                  end
                end
              end
              STG_LEN_HI, STG_SOS_HI: begin
                len_hi = b;
                stage++;
              end
              STG_LEN_LO, STG_SOS_LO: begin
                seg_len = 32'({len_hi, b});
                if (stage == STG_SOS_LO) marker_at[2] = 21'(byte_pos - 21'd1 + seg_len);
                skip_left = (seg_len < 2) ? 17'd0 : 17'(seg_len - 2);
                stage = STG_FRAME;
              end
              default: begin
                stage = STG_FRAME;
              end
            endcase
          end
        end
        byte_pos++;
      end
      if (last) begin
        rep = '0;
        if (byte_pos < 4) rep.status = STATUS_SHORT;
        else if (magic_seen != 2'b11) rep.status = STATUS_BAD_MAGIC;
        else if (phase < PHASE_DONE) rep.status = STATUS_NO_DQT0 + phase;
        else rep.status = STATUS_OK;
        if (rep.status == STATUS_OK) begin
          rep.quant0_offset = marker_at[0][19:0];
          rep.quant1_offset = marker_at[1][19:0];
          rep.scan_start = marker_at[2][19:0];
          rep.scan_length = (marker_at[3] >= marker_at[2]) ? marker_at[3] - marker_at[2] : '0;
        end
        expected_reports.push_back(rep);
        clear();
      end
    endfunction

    function void check_report(result_t got);
      result_t exp_rep;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: status %0d", got.status);
        errors++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got.status !== exp_rep.status) begin
          $error("status: expected %0d, actual %0d", exp_rep.status, got.status);
          errors++;
        end
        if (got.quant0_offset !== exp_rep.quant0_offset) begin
          $error("quant0_offset: expected %0d, actual %0d",
                 exp_rep.quant0_offset, got.quant0_offset);
          errors++;
        end
        if (got.quant1_offset !== exp_rep.quant1_offset) begin
          $error("quant1_offset: expected %0d, actual %0d",
                 exp_rep.quant1_offset, got.quant1_offset);
          errors++;
        end
        if (got.scan_start !== exp_rep.scan_start) begin
          $error("scan_start: expected %0d, actual %0d", exp_rep.scan_start, got.scan_start);
          errors++;
        end
        if (got.scan_length !== exp_rep.scan_length) begin
          $error("scan_length: expected %0d, actual %0d", exp_rep.scan_length, got.scan_length);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [19:0] quant0_offset_o;
  logic [19:0] quant1_offset_o;
  logic [19:0] scan_start_o;
  logic [20:0] scan_length_o;

  marker_scoreboard reports;
  logic [7:0]       frame_bytes [$];
  int               sent_bytes;

  jpeg_marker_segment_locator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .quant0_offset_o(quant0_offset_o),
    .quant1_offset_o(quant1_offset_o),
    .scan_start_o   (scan_start_o),
    .scan_length_o  (scan_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] any_marker_byte();
    case ($urandom_range(0, 8))
      0: return BYTE_FF;
      1: return MARKER_SOI;
      2: return MARKER_EOI;
      3: return MARKER_SOS;
      4: return MARKER_DQT;
      5: return MARKER_APP0;
      6: return MARKER_DHT;
      7: return MARKER_SOF0;
      default: return BYTE_ZERO;
    endcase
  endfunction

  // Most segments are short; a few carry a length below two or a length so
  // large that the jump runs past the end of the frame.
  function automatic void add_segment(logic [7:0] kind);
    int unsigned seg_len;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) seg_len = $urandom_range(0, 1);
    else if (pick < 9) seg_len = 16'hFF00 + $urandom_range(0, 255);
    else seg_len = $urandom_range(2, 7);
    frame_bytes.push_back(BYTE_FF);
    frame_bytes.push_back(kind);
    frame_bytes.push_back(seg_len[15:8]);
    frame_bytes.push_back(seg_len[7:0]);
    for (int i = 2; i < seg_len && i < 10; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_filler();
    case ($urandom_range(0, 6))
      0: add_segment(MARKER_APP0);
      1: add_segment(MARKER_DHT);
      2: add_segment(MARKER_SOF0);
      3: begin
        frame_bytes.push_back(BYTE_FF);
        frame_bytes.push_back(($urandom_range(0, 1) == 0) ? MARKER_COM
                              : MARKER_RST0 + 8'($urandom_range(0, 7)));
      end
      4: begin
        frame_bytes.push_back(BYTE_FF);
        frame_bytes.push_back(BYTE_ZERO);
      end
      5: begin
        frame_bytes.push_back(BYTE_FF);
        frame_bytes.push_back(BYTE_FF);
      end
      default: frame_bytes.push_back(8'($urandom_range(0, 254)));
    endcase
  endfunction

  function automatic void compose_frame();
    int         cut;
    logic [7:0] b;
    frame_bytes.delete();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 24)) begin
        frame_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                           : any_marker_byte());
      end
    end else begin
      frame_bytes.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                          : BYTE_FF);
      frame_bytes.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                          : MARKER_SOI);
      repeat ($urandom_range(0, 2)) add_filler();
      add_segment(MARKER_DQT);
      repeat ($urandom_range(0, 1)) add_filler();
      add_segment(MARKER_DQT);
      repeat ($urandom_range(0, 2)) add_filler();
      add_segment(MARKER_SOS);
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        frame_bytes.push_back(b);
        if (b == BYTE_FF) frame_bytes.push_back(BYTE_ZERO);
      end
      frame_bytes.push_back(BYTE_FF);
      frame_bytes.push_back(MARKER_EOI);
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    reports.take_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_frame();
    bit quiet;
    quiet = ($urandom_range(0, 2) == 0);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1,
                quiet ? 0 : $urandom_range(0, MAX_WAIT));
    end
  endtask

  initial begin
    int hold;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      reports.check_report('{status_o, quant0_offset_o, quant1_offset_o,
                             scan_start_o, scan_length_o});
    end
  end

  initial begin
    reports = new();
    sent_bytes = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    frame_bytes = '{BYTE_FF};
    send_frame();
    frame_bytes = '{BYTE_FF, MARKER_SOI, BYTE_FF};
    send_frame();
    frame_bytes = '{BYTE_ZERO, MARKER_SOI, BYTE_FF, MARKER_DQT};
    send_frame();
    frame_bytes = '{BYTE_FF, MARKER_SOI, BYTE_FF, MARKER_DQT, BYTE_ZERO, 8'h02,
                    BYTE_FF, MARKER_DQT, BYTE_ZERO, 8'h02, BYTE_FF, MARKER_SOS,
                    BYTE_ZERO, 8'h02, BYTE_FF, MARKER_EOI};
    send_frame();

    while (sent_bytes < TARGET_BYTES) begin
      compose_frame();
      send_frame();
    end
    in_valid_i <= 1'b0;

    while (reports.expected_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (reports.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
